### rtl/core/spa_pkg.sv
// ----------------------------------------------------------------------------
// spa_pkg
// Types, widths and helpers shared by the seam pair attraction unit.
// ----------------------------------------------------------------------------
package spa_pkg;

	localparam int IDX_W   = 16;
	localparam int CRD_W   = 32;
	localparam int STEP_W  = 31;
	localparam int MAG_W   = 32;
	localparam int SQ_W    = 2 * MAG_W;
	localparam int PROD_W  = MAG_W + STEP_W;
	localparam int ST2_W   = 2 * STEP_W;
	localparam int SUM_W   = SQ_W + 2;
	localparam int ROOT_W  = SUM_W / 2;
	localparam int REM_W   = ROOT_W + 2;
	localparam int DEN_W   = ROOT_W + 1;
	localparam int QUO_W   = STEP_W - 1;
	localparam int SQRT_STEPS = ROOT_W;
	localparam int DIV_STEPS  = QUO_W;
	localparam int AXES    = 3;

	localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(655);

	typedef struct packed {
		logic [IDX_W-1:0]        first_index;
		logic [IDX_W-1:0]        second_index;
		logic signed [CRD_W-1:0] ax;
		logic signed [CRD_W-1:0] ay;
		logic signed [CRD_W-1:0] az;
		logic signed [CRD_W-1:0] bx;
		logic signed [CRD_W-1:0] by;
		logic signed [CRD_W-1:0] bz;
		logic                    last_pair;
	} in_t;

	typedef struct packed {
		logic [IDX_W-1:0]        out_first_index;
		logic [IDX_W-1:0]        out_second_index;
		logic signed [CRD_W-1:0] new_ax;
		logic signed [CRD_W-1:0] new_ay;
		logic signed [CRD_W-1:0] new_az;
		logic signed [CRD_W-1:0] new_bx;
		logic signed [CRD_W-1:0] new_by;
		logic signed [CRD_W-1:0] new_bz;
		logic                    merged;
		logic                    out_last_pair;
	} out_t;

	// side data that rides along the whole pipe; prod becomes the divider remainder
	typedef struct packed {
		logic [IDX_W-1:0]             first_index;
		logic [IDX_W-1:0]             second_index;
		logic [AXES-1:0][CRD_W-1:0]   a;
		logic [AXES-1:0][CRD_W-1:0]   b;
		logic [AXES-1:0]              neg;
		logic [AXES-1:0][PROD_W-1:0]  prod;
		logic                         merge;
		logic                         last_pair;
	} pass_t;

	typedef struct packed {
		logic [SUM_W-1:0]  s;
		logic [REM_W-1:0]  rem;
		logic [ROOT_W-1:0] root;
	} sqrt_t;

	typedef struct packed {
		logic [DEN_W-1:0]            den;
		logic [AXES-1:0][QUO_W-1:0]  quo;
	} div_t;

	// clamp a 34-bit signed sum to the 32-bit range
	function automatic logic [CRD_W-1:0] sat34(input logic signed [CRD_W+1:0] v);
		logic [CRD_W-1:0] r;
		if (v > 34'sh0_7FFF_FFFF)
			r = {1'b0, {(CRD_W-1){1'b1}}};
		else if (v < -34'sh0_8000_0000)
			r = {1'b1, {(CRD_W-1){1'b0}}};
		else
			r = v[CRD_W-1:0];
		return r;
	endfunction

endpackage

### rtl/core/spa_sqrt_cell.sv
// ----------------------------------------------------------------------------
// spa_sqrt_cell
// One digit of the floor square root, with its own pipeline register.
// ----------------------------------------------------------------------------
module spa_sqrt_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            valid_i,
	output logic            ready_o,
	input  spa_pkg::pass_t  pass_i,
	input  spa_pkg::sqrt_t  st_i,
	output logic            valid_o,
	input  logic            ready_i,
	output spa_pkg::pass_t  pass_o,
	output spa_pkg::sqrt_t  st_o
);
	import spa_pkg::*;

	logic             v_q;
	pass_t            pass_q;
	sqrt_t            st_q;
	sqrt_t            st_nx;
	logic [REM_W-1:0] rem_w;
	logic [REM_W-1:0] trial;

	always_comb begin
		rem_w = {st_i.rem[REM_W-3:0], st_i.s[SUM_W-1 -: 2]};
		trial = {st_i.root, 2'b01};
		st_nx.s = {st_i.s[SUM_W-3:0], 2'b00};
		if (rem_w >= trial) begin
			st_nx.rem  = rem_w - trial;
			st_nx.root = {st_i.root[ROOT_W-2:0], 1'b1};
		end else begin
			st_nx.rem  = rem_w;
			st_nx.root = {st_i.root[ROOT_W-2:0], 1'b0};
		end
	end

	assign ready_o = !v_q || ready_i;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (ready_o) begin
			v_q <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_i && ready_o) begin
			pass_q <= pass_i;
			st_q   <= st_nx;
		end
	end

	assign valid_o = v_q;
	assign pass_o  = pass_q;
	assign st_o    = st_q;

endmodule

### rtl/core/spa_div_cell.sv
// ----------------------------------------------------------------------------
// spa_div_cell
// One restoring quotient bit for all three axes, with its own register.
// ----------------------------------------------------------------------------
module spa_div_cell #(
	parameter int SHIFT = 0
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            valid_i,
	output logic            ready_o,
	input  spa_pkg::pass_t  pass_i,
	input  spa_pkg::div_t   st_i,
	output logic            valid_o,
	input  logic            ready_i,
	output spa_pkg::pass_t  pass_o,
	output spa_pkg::div_t   st_o
);
	import spa_pkg::*;

	localparam int CMP_W = DEN_W + QUO_W;

	logic             v_q;
	pass_t            pass_q;
	div_t             st_q;
	pass_t            pass_nx;
	div_t             st_nx;
	logic [CMP_W-1:0] dsh;
	logic [CMP_W-1:0] rem_x;

	always_comb begin
		dsh     = CMP_W'(st_i.den) << SHIFT;
		pass_nx = pass_i;
		st_nx   = st_i;
		rem_x   = '0;
		for (int j = 0; j < AXES; j++) begin
			rem_x = CMP_W'(pass_i.prod[j]);
			if (rem_x >= dsh) begin
				pass_nx.prod[j] = PROD_W'(rem_x - dsh);
				st_nx.quo[j]    = {st_i.quo[j][QUO_W-2:0], 1'b1};
			end else begin
				st_nx.quo[j]    = {st_i.quo[j][QUO_W-2:0], 1'b0};
			end
		end
	end

	assign ready_o = !v_q || ready_i;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (ready_o) begin
			v_q <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_i && ready_o) begin
			pass_q <= pass_nx;
			st_q   <= st_nx;
		end
	end

	assign valid_o = v_q;
	assign pass_o  = pass_q;
	assign st_o    = st_q;

endmodule

### rtl/core/seam_pair_attraction_unit.sv
// ----------------------------------------------------------------------------
// seam_pair_attraction_unit
// Distance constraint step for one seam pair: moves both points half a step
// toward each other, or merges them at the midpoint when at most a step apart.
// ----------------------------------------------------------------------------
//  channel | signals                         | transfer when
//  --------+---------------------------------+----------------------------
//  in      | in_valid, in_ready, in_data     | in_valid && in_ready
//  out     | out_valid, out_ready, out_data  | out_valid && out_ready
//  cfg     | cfg_we, cfg_wdata (seam_step)   | cfg_we
//
//  one pair per cycle while out_ready stays high; the pipe holds three
//  front stages (difference, multipliers, sum and compare), 33 square root
//  cells, 30 divider cells and the output register.
//  every cell holds its item only while the next cell is full and stalled,
//  so bubbles close up and the input keeps flowing until the pipe is full.
//  reset empties the pipe and loads seam_step with 655.
// ----------------------------------------------------------------------------
module seam_pair_attraction_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  spa_pkg::in_t                  in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output spa_pkg::out_t                 out_data,
	input  logic                          cfg_we,
	input  logic [spa_pkg::STEP_W-1:0]    cfg_wdata
);
	import spa_pkg::*;

	logic [STEP_W-1:0] step_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_RESET;
		end else if (cfg_we) begin
			step_q <= cfg_wdata;
		end
	end

	// stage 1: differences and magnitudes
	logic                         v_s1, v_s2, v_s3;
	logic                         rdy1, rdy2, rdy3;
	pass_t                        pass_s1, pass_s2, pass_s3;
	logic [AXES-1:0][MAG_W-1:0]   mag_s1;
	logic [AXES-1:0][SQ_W-1:0]    sq_s2;
	logic [ST2_W-1:0]             st2_s2;
	logic [SUM_W-1:0]             sum_s3;
	pass_t                        pass_in;
	logic [AXES-1:0][MAG_W-1:0]   mag_in;
	logic signed [CRD_W:0]        diff;
	logic [SUM_W-1:0]             sum_w;
	pass_t                        pass_nx2;
	pass_t                        pass_nx3;

	always_comb begin
		pass_in              = '0;
		pass_in.first_index  = in_data.first_index;
		pass_in.second_index = in_data.second_index;
		pass_in.a            = {in_data.az, in_data.ay, in_data.ax};
		pass_in.b            = {in_data.bz, in_data.by, in_data.bx};
		pass_in.last_pair    = in_data.last_pair;
		mag_in               = '0;
		diff                 = '0;
		for (int j = 0; j < AXES; j++) begin
			diff = $signed({pass_in.b[j][CRD_W-1], pass_in.b[j]})
				- $signed({pass_in.a[j][CRD_W-1], pass_in.a[j]});
			pass_in.neg[j] = diff[CRD_W];
			mag_in[j] = diff[CRD_W] ? MAG_W'(-diff) : MAG_W'(diff);
		end
	end

	assign in_ready = !v_s1 || rdy2;
	assign rdy2     = !v_s2 || rdy3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (in_ready) v_s1 <= in_valid;
			if (rdy2)     v_s2 <= v_s1;
			if (rdy3)     v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			pass_s1 <= pass_in;
			mag_s1  <= mag_in;
		end
	end

	// stage 2: squares, step products and the squared threshold
	always_comb begin
		pass_nx2 = pass_s1;
		for (int j = 0; j < AXES; j++) begin
			pass_nx2.prod[j] = mag_s1[j] * PROD_W'(step_q);
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1 && rdy2) begin
			pass_s2 <= pass_nx2;
			for (int j = 0; j < AXES; j++) begin
				sq_s2[j] <= SQ_W'(mag_s1[j]) * SQ_W'(mag_s1[j]);
			end
			st2_s2 <= ST2_W'(step_q) * ST2_W'(step_q);
		end
	end

	// stage 3: sum of squares and the merge decision
	always_comb begin
		sum_w = SUM_W'(sq_s2[0]) + SUM_W'(sq_s2[1]) + SUM_W'(sq_s2[2]);
		pass_nx3       = pass_s2;
		pass_nx3.merge = (sum_w <= SUM_W'(st2_s2));
	end

	always_ff @(posedge clk) begin
		if (v_s2 && rdy3) begin
			pass_s3 <= pass_nx3;
			sum_s3  <= sum_w;
		end
	end

	// square root chain
	logic  sq_v   [SQRT_STEPS+1];
	logic  sq_r   [SQRT_STEPS+1];
	pass_t sq_p   [SQRT_STEPS+1];
	sqrt_t sq_st  [SQRT_STEPS+1];

	assign sq_v[0]         = v_s3;
	assign rdy3            = !v_s3 || sq_r[0];
	assign sq_p[0]         = pass_s3;
	assign sq_st[0].s      = sum_s3;
	assign sq_st[0].rem    = '0;
	assign sq_st[0].root   = '0;

	for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
		spa_sqrt_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.valid_i (sq_v[k]),
			.ready_o (sq_r[k]),
			.pass_i  (sq_p[k]),
			.st_i    (sq_st[k]),
			.valid_o (sq_v[k+1]),
			.ready_i (sq_r[k+1]),
			.pass_o  (sq_p[k+1]),
			.st_o    (sq_st[k+1])
		);
	end

	// divider chain, most significant quotient bit first
	logic  dv_v  [DIV_STEPS+1];
	logic  dv_r  [DIV_STEPS+1];
	pass_t dv_p  [DIV_STEPS+1];
	div_t  dv_st [DIV_STEPS+1];

	assign dv_v[0]          = sq_v[SQRT_STEPS];
	assign sq_r[SQRT_STEPS] = dv_r[0];
	assign dv_p[0]          = sq_p[SQRT_STEPS];
	assign dv_st[0].den     = {sq_st[SQRT_STEPS].root, 1'b0};
	assign dv_st[0].quo     = '0;

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
		spa_div_cell #(
			.SHIFT (DIV_STEPS - 1 - k)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.valid_i (dv_v[k]),
			.ready_o (dv_r[k]),
			.pass_i  (dv_p[k]),
			.st_i    (dv_st[k]),
			.valid_o (dv_v[k+1]),
			.ready_i (dv_r[k+1]),
			.pass_o  (dv_p[k+1]),
			.st_o    (dv_st[k+1])
		);
	end

	// output register: apply offsets or midpoints with saturation
	logic                        ov_q;
	out_t                        out_q;
	out_t                        out_nx;
	pass_t                       fp;
	logic [AXES-1:0][CRD_W-1:0]  na, nb;
	logic signed [CRD_W+1:0]     off, sa, sb;
	logic signed [CRD_W:0]       mid;

	assign dv_r[DIV_STEPS] = !ov_q || out_ready;

	always_comb begin
		fp  = dv_p[DIV_STEPS];
		na  = '0;
		nb  = '0;
		off = '0;
		sa  = '0;
		sb  = '0;
		mid = '0;
		for (int j = 0; j < AXES; j++) begin
			off = $signed({4'b0000, dv_st[DIV_STEPS].quo[j]});
			if (fp.neg[j]) off = -off;
			sa = $signed({{2{fp.a[j][CRD_W-1]}}, fp.a[j]}) + off;
			sb = $signed({{2{fp.b[j][CRD_W-1]}}, fp.b[j]}) - off;
			mid = ($signed({fp.a[j][CRD_W-1], fp.a[j]})
				+ $signed({fp.b[j][CRD_W-1], fp.b[j]})) >>> 1;
			if (fp.merge) begin
				na[j] = mid[CRD_W-1:0];
				nb[j] = mid[CRD_W-1:0];
			end else begin
				na[j] = sat34(sa);
				nb[j] = sat34(sb);
			end
		end
		out_nx.out_first_index  = fp.first_index;
		out_nx.out_second_index = fp.second_index;
		out_nx.new_ax           = na[0];
		out_nx.new_ay           = na[1];
		out_nx.new_az           = na[2];
		out_nx.new_bx           = nb[0];
		out_nx.new_by           = nb[1];
		out_nx.new_bz           = nb[2];
		out_nx.merged           = fp.merge;
		out_nx.out_last_pair    = fp.last_pair;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (dv_r[DIV_STEPS]) begin
			ov_q <= dv_v[DIV_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (dv_v[DIV_STEPS] && dv_r[DIV_STEPS]) begin
			out_q <= out_nx;
		end
	end

	assign out_valid = ov_q;
	assign out_data  = out_q;

	// input only backs up when the output is holding a result
	a_stall_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (out_valid && !out_ready))
		else $error("input stalled without output back-pressure");

	// a merged pair leaves both points at the same place
	a_merge_same: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.merged) |->
		(out_data.new_ax == out_data.new_bx && out_data.new_ay == out_data.new_by
		&& out_data.new_az == out_data.new_bz))
		else $error("merged pair has different positions");

endmodule
